// ===== rtl/shm_pkg.sv =====
// shared types and constants for the subsystem health monitor
package shm_pkg;

	// sizes
	localparam int NUM_SUBSYSTEMS = 9;
	localparam int IDX_W          = (NUM_SUBSYSTEMS > 16) ? 5 : $clog2(NUM_SUBSYSTEMS);
	localparam int TALLY_W        = 32;
	localparam int ADDR_W         = 4;
	localparam int DATA_W         = 32;

	// operation codes
	localparam logic [2:0] OP_SUCCESS     = 3'd0;
	localparam logic [2:0] OP_FAIL        = 3'd1;
	localparam logic [2:0] OP_TIMEOUT     = 3'd2;
	localparam logic [2:0] OP_UNAVAILABLE = 3'd3;
	localparam logic [2:0] OP_RECOVERING  = 3'd4;
	localparam logic [2:0] OP_BOOT_DONE   = 3'd5;
	localparam logic [2:0] OP_RECOVERY    = 3'd6;
	localparam logic [2:0] OP_READ        = 3'd7;

	// health states
	localparam logic [2:0] ST_HEALTHY     = 3'd0;
	localparam logic [2:0] ST_DEGRADED    = 3'd1;
	localparam logic [2:0] ST_FAULTED     = 3'd2;
	localparam logic [2:0] ST_RECOVERING  = 3'd3;
	localparam logic [2:0] ST_UNAVAILABLE = 3'd4;

	// system modes
	localparam logic [2:0] MODE_BOOTING   = 3'd0;
	localparam logic [2:0] MODE_NORMAL    = 3'd1;
	localparam logic [2:0] MODE_DEGRADED  = 3'd2;
	localparam logic [2:0] MODE_SAFE      = 3'd3;
	localparam logic [2:0] MODE_RECOVERY  = 3'd4;

	// register indexes
	localparam logic [1:0] REG_DEGRADE_THR = 2'd0;
	localparam logic [1:0] REG_FAULT_THR   = 2'd1;
	localparam logic [1:0] REG_PRIMARY     = 2'd2;
	localparam logic [1:0] REG_SECONDARY   = 2'd3;

	// reset values of the registers
	localparam logic [7:0] DEGRADE_THR_RST = 8'd3;
	localparam logic [7:0] FAULT_THR_RST   = 8'd5;
	localparam logic [4:0] PRIMARY_RST     = 5'd5;
	localparam logic [4:0] SECONDARY_RST   = 5'd4;

	typedef struct packed {
		logic [2:0] operation;
		logic [4:0] subsystem;
	} shm_in_t;

	typedef struct packed {
		logic               accepted;
		logic [2:0]         health_state;
		logic [2:0]         system_mode;
		logic               in_safe_mode;
		logic [7:0]         run_of_failures;
		logic [TALLY_W-1:0] successes;
		logic [TALLY_W-1:0] failures;
		logic [TALLY_W-1:0] timeouts;
		logic [TALLY_W-1:0] degrade_events;
		logic [TALLY_W-1:0] fault_events;
	} shm_out_t;

endpackage

// ===== rtl/subsystem_health_monitor.sv =====
// subsystem health monitor: per-subsystem fault records and system mode
// an event transfers into the input register, and its result loads into the result
// register when the event advances (input register, result register)
// throughput: one event per cycle; the per-event update is one pass over flop state
// the only stall source is a held result that the downstream side has not taken
// reset: all subsystems unavailable, records and runs zero, mode booting,
// thresholds 3 and 5, critical subsystems 5 and 4
module subsystem_health_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  shm_pkg::shm_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output shm_pkg::shm_out_t             out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [shm_pkg::ADDR_W-1:0]    paddr,
	input  logic [shm_pkg::DATA_W-1:0]    pwdata,
	output logic [shm_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import shm_pkg::*;

	// configuration registers
	logic [7:0] degrade_thr_q;
	logic [7:0] fault_thr_q;
	logic [4:0] primary_q;
	logic [4:0] secondary_q;

	// per-subsystem records
	logic [2:0]         state_q   [NUM_SUBSYSTEMS];
	logic [7:0]         run_q     [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] succ_q    [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] fail_q    [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] tmo_q     [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] deg_cnt_q [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] flt_cnt_q [NUM_SUBSYSTEMS];
	logic [2:0]         mode_q;

	logic [2:0]         state_n   [NUM_SUBSYSTEMS];
	logic [7:0]         run_n     [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] succ_n    [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] fail_n    [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] tmo_n     [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] deg_cnt_n [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] flt_cnt_n [NUM_SUBSYSTEMS];
	logic [2:0]         mode_n;

	// input stage and result register
	logic       valid_s1;
	logic [2:0] op_s1;
	logic [4:0] sub_s1;
	logic       out_valid_q;
	shm_out_t   out_q;
	logic       adv;

	// event decode
	logic             sub_ok;
	logic [IDX_W-1:0] idx;
	logic [IDX_W-1:0] pidx;
	logic [IDX_W-1:0] sidx;
	logic             p_ok;
	logic             s_ok;
	logic             upd_en;
	logic             boot_en;

	// addressed entry update
	logic [2:0]         st_a;
	logic [2:0]         st_b;
	logic [7:0]         run_b;
	logic [TALLY_W-1:0] succ_b;
	logic [TALLY_W-1:0] fail_b;
	logic [TALLY_W-1:0] tmo_b;
	logic [TALLY_W-1:0] deg_b;
	logic [TALLY_W-1:0] flt_b;

	logic [NUM_SUBSYSTEMS-1:0] faulted_v;
	logic [NUM_SUBSYSTEMS-1:0] degraded_v;
	shm_out_t                  res;

	// handshake
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pready    = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degrade_thr_q <= DEGRADE_THR_RST;
			fault_thr_q   <= FAULT_THR_RST;
			primary_q     <= PRIMARY_RST;
			secondary_q   <= SECONDARY_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_DEGRADE_THR: degrade_thr_q <= pwdata[7:0];
				REG_FAULT_THR:   fault_thr_q   <= pwdata[7:0];
				REG_PRIMARY:     primary_q     <= pwdata[4:0];
				REG_SECONDARY:   secondary_q   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// configuration reads
	always_comb begin
		case (paddr[3:2])
			REG_DEGRADE_THR: prdata = {{(DATA_W-8){1'b0}}, degrade_thr_q};
			REG_FAULT_THR:   prdata = {{(DATA_W-8){1'b0}}, fault_thr_q};
			REG_PRIMARY:     prdata = {{(DATA_W-5){1'b0}}, primary_q};
			REG_SECONDARY:   prdata = {{(DATA_W-5){1'b0}}, secondary_q};
			default:         prdata = '0;
		endcase
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1  <= in_data.operation;
			sub_s1 <= in_data.subsystem;
		end
	end

	// index checks
	assign sub_ok  = {1'b0, sub_s1} < 6'(NUM_SUBSYSTEMS);
	assign p_ok    = {1'b0, primary_q} < 6'(NUM_SUBSYSTEMS);
	assign s_ok    = {1'b0, secondary_q} < 6'(NUM_SUBSYSTEMS);
	assign idx     = sub_ok ? sub_s1[IDX_W-1:0] : '0;
	assign pidx    = p_ok ? primary_q[IDX_W-1:0] : '0;
	assign sidx    = s_ok ? secondary_q[IDX_W-1:0] : '0;
	assign upd_en  = sub_ok && (op_s1 inside {OP_SUCCESS, OP_FAIL, OP_TIMEOUT,
		OP_UNAVAILABLE, OP_RECOVERING});
	assign boot_en = (op_s1 == OP_BOOT_DONE) && p_ok && (state_q[pidx] == ST_UNAVAILABLE);

	// new record of the addressed subsystem
	always_comb begin
		st_a   = state_q[idx];
		run_b  = run_q[idx];
		succ_b = succ_q[idx];
		fail_b = fail_q[idx];
		tmo_b  = tmo_q[idx];
		deg_b  = deg_cnt_q[idx];
		flt_b  = flt_cnt_q[idx];
		if (op_s1 == OP_SUCCESS) begin
			if (st_a == ST_UNAVAILABLE) begin
				st_a = ST_HEALTHY;
			end
			succ_b = succ_b + 1'b1;
			run_b  = '0;
		end else if (op_s1 inside {OP_FAIL, OP_TIMEOUT}) begin
			if (st_a == ST_UNAVAILABLE) begin
				st_a = ST_DEGRADED;
			end
			if (op_s1 == OP_FAIL) begin
				fail_b = fail_b + 1'b1;
			end else begin
				tmo_b = tmo_b + 1'b1;
			end
			if (run_b != 8'hFF) begin
				run_b = run_b + 1'b1;
			end
		end
		st_b = st_a;
		// health machine step after success or failure
		if (op_s1 inside {OP_SUCCESS, OP_FAIL, OP_TIMEOUT}) begin
			case (st_a)
				ST_HEALTHY: begin
					if (run_b >= degrade_thr_q) begin
						st_b  = ST_DEGRADED;
						deg_b = deg_b + 1'b1;
					end
				end
				ST_DEGRADED: begin
					if (run_b >= fault_thr_q) begin
						st_b  = ST_FAULTED;
						flt_b = flt_b + 1'b1;
					end else if (run_b == 8'd0) begin
						st_b = ST_HEALTHY;
					end
				end
				ST_RECOVERING: begin
					if (run_b == 8'd0) begin
						st_b = ST_HEALTHY;
					end else if (run_b >= degrade_thr_q) begin
						st_b  = ST_FAULTED;
						flt_b = flt_b + 1'b1;
					end
				end
				default: ;
			endcase
		end else if (op_s1 == OP_UNAVAILABLE) begin
			st_b = ST_UNAVAILABLE;
		end else if (op_s1 == OP_RECOVERING) begin
			st_b  = ST_RECOVERING;
			run_b = '0;
		end
	end

	// next records of all subsystems
	always_comb begin
		for (int i = 0; i < NUM_SUBSYSTEMS; i++) begin
			state_n[i]   = state_q[i];
			run_n[i]     = run_q[i];
			succ_n[i]    = succ_q[i];
			fail_n[i]    = fail_q[i];
			tmo_n[i]     = tmo_q[i];
			deg_cnt_n[i] = deg_cnt_q[i];
			flt_cnt_n[i] = flt_cnt_q[i];
			if (upd_en && idx == IDX_W'(i)) begin
				state_n[i]   = st_b;
				run_n[i]     = run_b;
				succ_n[i]    = succ_b;
				fail_n[i]    = fail_b;
				tmo_n[i]     = tmo_b;
				deg_cnt_n[i] = deg_b;
				flt_cnt_n[i] = flt_b;
			end
			if (boot_en && pidx == IDX_W'(i)) begin
				state_n[i] = ST_HEALTHY;
				succ_n[i]  = TALLY_W'(1);
			end
			faulted_v[i]  = state_n[i] == ST_FAULTED;
			degraded_v[i] = (state_n[i] == ST_DEGRADED) || (state_n[i] == ST_RECOVERING);
		end
	end

	// system mode
	always_comb begin
		mode_n = mode_q;
		if (upd_en || (op_s1 == OP_BOOT_DONE && mode_q == MODE_BOOTING)) begin
			if (p_ok && s_ok && faulted_v[pidx] && faulted_v[sidx]) begin
				mode_n = MODE_SAFE;
			end else if ((|faulted_v) || ((degraded_v & (degraded_v - 1'b1)) != '0)) begin
				mode_n = MODE_DEGRADED;
			end else begin
				mode_n = MODE_NORMAL;
			end
		end else if (op_s1 == OP_RECOVERY) begin
			mode_n = MODE_RECOVERY;
		end
	end

	// result of the event
	always_comb begin
		res                  = '0;
		res.accepted         = sub_ok || (op_s1 inside {OP_BOOT_DONE, OP_RECOVERY});
		res.system_mode      = mode_n;
		res.in_safe_mode     = mode_n == MODE_SAFE;
		if (sub_ok) begin
			res.health_state     = state_n[idx];
			res.run_of_failures  = run_n[idx];
			res.successes        = succ_n[idx];
			res.failures         = fail_n[idx];
			res.timeouts         = tmo_n[idx];
			res.degrade_events   = deg_cnt_n[idx];
			res.fault_events     = flt_cnt_n[idx];
		end
	end

	// record and mode update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SUBSYSTEMS; i++) begin
				state_q[i]   <= ST_UNAVAILABLE;
				run_q[i]     <= '0;
				succ_q[i]    <= '0;
				fail_q[i]    <= '0;
				tmo_q[i]     <= '0;
				deg_cnt_q[i] <= '0;
				flt_cnt_q[i] <= '0;
			end
			mode_q <= MODE_BOOTING;
		end else if (adv) begin
			for (int i = 0; i < NUM_SUBSYSTEMS; i++) begin
				state_q[i]   <= state_n[i];
				run_q[i]     <= run_n[i];
				succ_q[i]    <= succ_n[i];
				fail_q[i]    <= fail_n[i];
				tmo_q[i]     <= tmo_n[i];
				deg_cnt_q[i] <= deg_cnt_n[i];
				flt_cnt_q[i] <= flt_cnt_n[i];
			end
			mode_q <= mode_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

endmodule

// ===== tb/sv/subsystem_health_monitor_tb.sv =====
// self-checking testbench for the subsystem health monitor
module subsystem_health_monitor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import shm_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 4;

	// block ports
	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	shm_in_t           in_data  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	shm_out_t          out_data;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [ADDR_W-1:0] paddr    = '0;
	logic [DATA_W-1:0] pwdata   = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// shadow copy of the per-subsystem records and the system mode
	logic [2:0]         health        [NUM_SUBSYSTEMS];
	logic [7:0]         fail_run      [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] ok_count      [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] fail_total    [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] tmo_total     [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] degrade_count [NUM_SUBSYSTEMS];
	logic [TALLY_W-1:0] fault_count   [NUM_SUBSYSTEMS];
	logic [2:0]         sys_mode;
	logic [7:0]         degrade_thr;
	logic [7:0]         fault_thr;
	logic [4:0]         primary_idx;
	logic [4:0]         secondary_idx;

	// event backlog and the health reports still owed by the block
	shm_in_t  event_backlog[$];
	shm_out_t expected_reports[$];
	shm_out_t want_rep;

	int taken_count, launched_count, queued_total, err_count, quiet_cycles;
	int send_pause, send_calm, stall_left, stall_calm;
	int results_checked, safe_seen, rejected_seen, settings_used;

	subsystem_health_monitor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// critical subsystem counts as faulted only when its index exists
	function automatic bit is_down(logic [4:0] idx);
		return idx < NUM_SUBSYSTEMS && health[idx] == ST_FAULTED;
	endfunction

	// system mode from the spread of health states
	function automatic void refresh_mode();
		int n_faulted;
		int n_weak;
		n_faulted = 0;
		n_weak = 0;
		for (int i = 0; i < NUM_SUBSYSTEMS; i++) begin
			if (health[i] == ST_FAULTED)
				n_faulted++;
			else if (health[i] == ST_DEGRADED || health[i] == ST_RECOVERING)
				n_weak++;
		end
		if (is_down(primary_idx) && is_down(secondary_idx))
			sys_mode = MODE_SAFE;
		else if (n_faulted > 0 || n_weak >= 2)
			sys_mode = MODE_DEGRADED;
		else
			sys_mode = MODE_NORMAL;
	endfunction

	// health machine after a success, failure or timeout
	function automatic void step_health(int s);
		case (health[s])
			ST_HEALTHY: begin
				if (fail_run[s] >= degrade_thr) begin
					health[s] = ST_DEGRADED;
					degrade_count[s] = degrade_count[s] + 1'b1;
				end
			end
			ST_DEGRADED: begin
				if (fail_run[s] >= fault_thr) begin
					health[s] = ST_FAULTED;
					fault_count[s] = fault_count[s] + 1'b1;
				end else if (fail_run[s] == 8'd0) begin
					health[s] = ST_HEALTHY;
				end
			end
			ST_RECOVERING: begin
				if (fail_run[s] == 8'd0) begin
					health[s] = ST_HEALTHY;
				end else if (fail_run[s] >= degrade_thr) begin
					health[s] = ST_FAULTED;
					fault_count[s] = fault_count[s] + 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// update the shadow records for one event and build its report
	function automatic shm_out_t apply_event(shm_in_t ev);
		shm_out_t rep;
		int       s;
		bit       in_range;
		s = int'(ev.subsystem);
		in_range = s < NUM_SUBSYSTEMS;
		if (in_range) begin
			case (ev.operation)
				OP_SUCCESS: begin
					if (health[s] == ST_UNAVAILABLE)
						health[s] = ST_HEALTHY;
					ok_count[s] = ok_count[s] + 1'b1;
					fail_run[s] = '0;
					step_health(s);
					refresh_mode();
				end
				OP_FAIL, OP_TIMEOUT: begin
					if (health[s] == ST_UNAVAILABLE)
						health[s] = ST_DEGRADED;
					if (ev.operation == OP_FAIL)
						fail_total[s] = fail_total[s] + 1'b1;
					else
						tmo_total[s] = tmo_total[s] + 1'b1;
					if (fail_run[s] != 8'hFF)
						fail_run[s] = fail_run[s] + 1'b1;
					step_health(s);
					refresh_mode();
				end
				OP_UNAVAILABLE: begin
					health[s] = ST_UNAVAILABLE;
					refresh_mode();
				end
				OP_RECOVERING: begin
					health[s] = ST_RECOVERING;
					fail_run[s] = '0;
					refresh_mode();
				end
				default: ;
			endcase
		end
		// boot complete and recovery mode ignore the subsystem index
		if (ev.operation == OP_BOOT_DONE) begin
			if (primary_idx < NUM_SUBSYSTEMS && health[primary_idx] == ST_UNAVAILABLE) begin
				health[primary_idx] = ST_HEALTHY;
				ok_count[primary_idx] = TALLY_W'(1);
			end
			if (sys_mode == MODE_BOOTING)
				refresh_mode();
		end else if (ev.operation == OP_RECOVERY) begin
			sys_mode = MODE_RECOVERY;
		end
		rep = '0;
		rep.accepted = in_range || ev.operation == OP_BOOT_DONE || ev.operation == OP_RECOVERY;
		rep.system_mode = sys_mode;
		rep.in_safe_mode = sys_mode == MODE_SAFE;
		if (in_range) begin
			rep.health_state = health[s];
			rep.run_of_failures = fail_run[s];
			rep.successes = ok_count[s];
			rep.failures = fail_total[s];
			rep.timeouts = tmo_total[s];
			rep.degrade_events = degrade_count[s];
			rep.fault_events = fault_count[s];
		end
		return rep;
	endfunction

	function automatic void check_field(string name, logic [TALLY_W-1:0] want,
			logic [TALLY_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	// gap length: mostly none or short, now and then long
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [4:0] pick_sub();
		if ($urandom_range(0, 99) < 88)
			return 5'($urandom_range(0, NUM_SUBSYSTEMS - 1));
		return 5'($urandom_range(0, 31));
	endfunction

	function automatic void add_event(logic [2:0] op, logic [4:0] sub);
		shm_in_t e;
		e.operation = op;
		e.subsystem = sub;
		event_backlog.push_back(e);
		queued_total++;
	endfunction

	// random traffic: mostly failure runs and recovery sequences, some noise
	function automatic void queue_scenarios(int count);
		int         goal;
		int         k;
		logic [4:0] s;
		goal = queued_total + count;
		while (queued_total < goal) begin
			s = pick_sub();
			k = $urandom_range(0, 99);
			if (k < 40) begin
				repeat ($urandom_range(1, 9))
					add_event($urandom_range(0, 1) ? OP_FAIL : OP_TIMEOUT, s);
				if ($urandom_range(0, 1))
					add_event(OP_SUCCESS, s);
			end else if (k < 55) begin
				add_event(OP_RECOVERING, s);
				repeat ($urandom_range(1, 4))
					add_event(3'($urandom_range(OP_SUCCESS, OP_TIMEOUT)), s);
			end else if (k < 65) begin
				add_event(OP_UNAVAILABLE, s);
				if ($urandom_range(0, 1))
					add_event(OP_BOOT_DONE, 5'($urandom_range(0, 31)));
			end else if (k < 72) begin
				add_event(OP_RECOVERY, 5'($urandom_range(0, 31)));
				add_event(OP_SUCCESS, s);
			end else if (k < 80) begin
				add_event(OP_READ, s);
			end else begin
				add_event(3'($urandom_range(OP_SUCCESS, OP_READ)), 5'($urandom_range(0, 31)));
			end
		end
	endfunction

	// one register write followed by a read back
	task automatic program_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] stored;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		stored = '0;
		case (idx)
			REG_DEGRADE_THR: begin
				degrade_thr = val[7:0];
				stored[7:0] = val[7:0];
			end
			REG_FAULT_THR: begin
				fault_thr = val[7:0];
				stored[7:0] = val[7:0];
			end
			REG_PRIMARY: begin
				primary_idx = val[4:0];
				stored[4:0] = val[4:0];
			end
			default: begin
				secondary_idx = val[4:0];
				stored[4:0] = val[4:0];
			end
		endcase
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("prdata", stored, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_setting(input logic [7:0] d_thr, input logic [7:0] f_thr,
			input logic [4:0] p_idx, input logic [4:0] s_idx);
		program_reg(REG_DEGRADE_THR, {24'd0, d_thr});
		program_reg(REG_FAULT_THR, {24'd0, f_thr});
		program_reg(REG_PRIMARY, {27'd0, p_idx});
		program_reg(REG_SECONDARY, {27'd0, s_idx});
		settings_used++;
	endtask

	// hold off until every queued event has produced its report
	task automatic wait_idle();
		do @(negedge clk);
		while (event_backlog.size() != 0 || launched_count != taken_count ||
				expected_reports.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// driver: event transfers from the backlog and random result stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || taken_count == launched_count) begin
				if (send_pause > 0) begin
					in_valid <= 1'b0;
					send_pause--;
				end else if (event_backlog.size() > 0) begin
					in_data <= event_backlog.pop_front();
					in_valid <= 1'b1;
					launched_count++;
					if (send_calm > 0) begin
						send_calm--;
					end else begin
						if ($urandom_range(0, 39) == 0)
							send_calm = $urandom_range(20, 60);
						send_pause = pick_pause();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end

			// downstream stalls
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (stall_calm > 0)
					stall_calm--;
				else if ($urandom_range(0, 39) == 0)
					stall_calm = $urandom_range(20, 60);
				else if ($urandom_range(0, 3) == 0)
					stall_left = pick_pause();
			end
		end
	end

	// monitor: predict on event transfers, check on result transfers
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (in_valid && !in_stall) begin
				taken_count++;
				expected_reports.push_back(apply_event(in_data));
				quiet_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				if (expected_reports.size() == 0) begin
					$error("result transfer with no event outstanding");
					err_count++;
				end else begin
					want_rep = expected_reports.pop_front();
					check_field("accepted", want_rep.accepted, out_data.accepted);
					check_field("health_state", want_rep.health_state, out_data.health_state);
					check_field("system_mode", want_rep.system_mode, out_data.system_mode);
					check_field("in_safe_mode", want_rep.in_safe_mode, out_data.in_safe_mode);
					check_field("run_of_failures", want_rep.run_of_failures,
						out_data.run_of_failures);
					check_field("successes", want_rep.successes, out_data.successes);
					check_field("failures", want_rep.failures, out_data.failures);
					check_field("timeouts", want_rep.timeouts, out_data.timeouts);
					check_field("degrade_events", want_rep.degrade_events,
						out_data.degrade_events);
					check_field("fault_events", want_rep.fault_events, out_data.fault_events);
					results_checked++;
					if (want_rep.in_safe_mode)
						safe_seen++;
					if (!want_rep.accepted)
						rejected_seen++;
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$error("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		for (int i = 0; i < NUM_SUBSYSTEMS; i++) begin
			health[i] = ST_UNAVAILABLE;
			fail_run[i] = '0;
			ok_count[i] = '0;
			fail_total[i] = '0;
			tmo_total[i] = '0;
			degrade_count[i] = '0;
			fault_count[i] = '0;
		end
		sys_mode = MODE_BOOTING;
		degrade_thr = DEGRADE_THR_RST;
		fault_thr = FAULT_THR_RST;
		primary_idx = PRIMARY_RST;
		secondary_idx = SECONDARY_RST;
		settings_used = 1;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: boot, index range edges, every operation, safe mode entry and exit
		add_event(OP_READ, 5'd0);
		add_event(OP_READ, 5'd31);
		add_event(OP_FAIL, 5'd9);
		add_event(OP_BOOT_DONE, 5'd31);
		add_event(OP_SUCCESS, 5'd0);
		add_event(OP_TIMEOUT, 5'd1);
		add_event(OP_RECOVERING, 5'd2);
		add_event(OP_UNAVAILABLE, 5'd2);
		add_event(OP_RECOVERY, 5'd20);
		add_event(OP_READ, 5'd8);
		add_event(OP_BOOT_DONE, 5'd0);
		repeat (5) add_event(OP_FAIL, PRIMARY_RST);
		repeat (5) add_event(OP_TIMEOUT, SECONDARY_RST);
		add_event(OP_SUCCESS, SECONDARY_RST);
		add_event(OP_RECOVERING, PRIMARY_RST);
		add_event(OP_SUCCESS, PRIMARY_RST);
		queue_scenarios(140);
		wait_idle();

		// lowest thresholds, critical pair at the index edges
		apply_setting(8'd1, 8'd1, 5'd0, 5'(NUM_SUBSYSTEMS - 1));
		queue_scenarios(140);
		wait_idle();

		// highest thresholds with criticals out of range; long failure storm saturates the run
		apply_setting(8'd255, 8'd255, 5'd31, 5'd30);
		add_event(OP_RECOVERING, 5'd3);
		add_event(OP_SUCCESS, 5'd3);
		for (int i = 0; i < 260; i++)
			add_event((i % 3 == 0) ? OP_TIMEOUT : OP_FAIL, 5'd3);
		queue_scenarios(40);
		wait_idle();

		// random low thresholds and criticals
		apply_setting(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
			5'($urandom_range(0, NUM_SUBSYSTEMS - 1)),
			5'($urandom_range(0, NUM_SUBSYSTEMS - 1)));
		queue_scenarios(140);
		wait_idle();

		apply_setting(8'd2, 8'd255, 5'(NUM_SUBSYSTEMS - 1), 5'd0);
		queue_scenarios(120);
		wait_idle();

		// back to the power-on settings
		apply_setting(DEGRADE_THR_RST, FAULT_THR_RST, PRIMARY_RST, SECONDARY_RST);
		queue_scenarios(80);
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Run covered %0d events under %0d register settings, %0d results checked",
			taken_count, settings_used, results_checked);
		$display("%0d events carried a rejected index, %0d results reported safe mode",
			rejected_seen, safe_seen);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
